### src/pst_pkg.sv
`timescale 1ns / 1ps
// Package for the perfect square tester: shared widths and defaults.
// No dependencies.
package pst_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned ROOT_W         = 16;

endpackage

### src/pst_cell.sv
`timescale 1ns / 1ps
// One stage of the square root chain: resolves one root bit per cycle.
// Depends on pst_pkg.
module pst_cell
  import pst_pkg::*;
#(
  parameter int unsigned ROOT_BITS = (VALUE_BITS_DEF + 1) / 2,
  parameter int unsigned STAGE     = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [ROOT_BITS+1:0]   rem_i,
  input  logic [ROOT_BITS-1:0]   root_i,
  input  logic [2*ROOT_BITS-1:0] val_i,
  output logic                   valid_o,
  output logic [ROOT_BITS+1:0]   rem_o,
  output logic [ROOT_BITS-1:0]   root_o,
  output logic [2*ROOT_BITS-1:0] val_o
);

  localparam int unsigned REM_W = ROOT_BITS + 2;
  localparam int unsigned VAL_W = 2 * ROOT_BITS;

  logic                 valid_q;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;
  logic [VAL_W-1:0]     val_q, val_d;

  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic [REM_W+1:0]     diff;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_i, val_i[VAL_W-1 -: 2]};
    trial  = (REM_W + 2)'({root_i, 2'b01});
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
    rem_d  = ge ? REM_W'(diff) : REM_W'(rem_sh);
    root_d = ROOT_BITS'({root_i, ge});
    val_d  = val_i << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    val_q  <= val_d;
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign val_o   = val_q;

  // remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q <= {root_q, 1'b0}))
    else $error("pst_cell: remainder out of range");

  // only STAGE+1 root bits can be resolved so far
  a_root_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((root_q >> (STAGE + 1)) == '0))
    else $error("pst_cell: root has bits beyond this stage");

  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (valid_q == $past(valid_i)))
    else $error("pst_cell: transaction lost or invented");

endmodule

### src/perfect_square_test_core.sv
`timescale 1ns / 1ps
// Perfect square tester top level: chain of pst_cell stages.
// Depends on pst_pkg and pst_cell.
//
// Takes one value per clock cycle; busy is never raised. Each transaction
// gives one result (floor square root and perfect-square flag) at the end
// of the chain of registered cells, one cell per root bit. The result is shown
// for a single cycle with done_o and cannot be held off by the receiver, so
// it must be captured when done_o is high.
module perfect_square_test_core
  import pst_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  done_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic                  is_square_o
);

  localparam int unsigned ROOT_BITS = (VALUE_BITS + 1) / 2;
  localparam int unsigned REM_W     = ROOT_BITS + 2;
  localparam int unsigned VAL_W     = 2 * ROOT_BITS;
  localparam int unsigned OUT_COPY  = (ROOT_BITS < ROOT_W) ? ROOT_BITS : ROOT_W;

  logic                 valid_s [ROOT_BITS+1];
  logic [REM_W-1:0]     rem_s   [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] root_s  [ROOT_BITS+1];
  logic [VAL_W-1:0]     val_s   [ROOT_BITS+1];

  assign busy       = 1'b0;
  assign valid_s[0] = start;
  assign rem_s[0]   = '0;
  assign root_s[0]  = '0;
  assign val_s[0]   = VAL_W'(value_i);

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
    pst_cell #(
      .ROOT_BITS(ROOT_BITS),
      .STAGE    (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[g]),
      .rem_i  (rem_s[g]),
      .root_i (root_s[g]),
      .val_i  (val_s[g]),
      .valid_o(valid_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .root_o (root_s[g+1]),
      .val_o  (val_s[g+1])
    );
  end

  always_comb begin
    root_o                 = '0;
    root_o[OUT_COPY-1:0]   = root_s[ROOT_BITS][OUT_COPY-1:0];
  end

  assign done_o      = valid_s[ROOT_BITS];
  assign is_square_o = (rem_s[ROOT_BITS] == '0);

endmodule

### tb/perfect_square_test_core_tb.sv
`timescale 1ns / 1ps
// Testbench for perfect_square_test_core: a directed table, then random values,
// each checked against its known table result or a bit-serial integer
// square root predictor. Depends on pst_pkg and perfect_square_test_core.
module perfect_square_test_core_tb;
  import pst_pkg::*;

  localparam int unsigned VB       = VALUE_BITS_DEF;
  localparam int unsigned LATENCY  = (VB + 1) / 2;
  localparam int unsigned N_DIR    = 16;
  localparam int unsigned N_RAND   = 1000;
  localparam int unsigned N_QUIET  = 150;
  localparam int unsigned MAX_ROOT = 46340;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              is_sq;
  } sqrt_res_t;

  typedef struct packed {
    logic [VB-1:0] val;
    logic          known;
    sqrt_res_t     res;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [VB-1:0]     value_i;
  logic              done_o;
  logic [ROOT_W-1:0] root_o;
  logic              is_square_o;

  sqrt_res_t   roots_due[$];
  int unsigned n_errors;
  dir_row_t    dir_tbl [N_DIR];

  perfect_square_test_core #(
    .VALUE_BITS(VB)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .done_o     (done_o),
    .root_o     (root_o),
    .is_square_o(is_square_o)
  );

  function automatic sqrt_res_t predict_sqrt(logic [VB-1:0] v);
    logic [63:0] x;
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] b;
    sqrt_res_t   r;
    x   = 64'(v) & ({64{1'b1}} >> (64 - VB));
    rem = x;
    acc = '0;
    b   = 64'h1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= acc + b) begin
        rem = rem - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    r.root  = acc[ROOT_W-1:0];
    r.is_sq = (acc * acc == x);
    return r;
  endfunction

  // squares and their neighbours, small values, and full-range noise
  function automatic logic [VB-1:0] rand_value();
    logic [31:0] r;
    int unsigned mode;
    mode = $urandom_range(0, 5);
    r    = $urandom_range(0, MAX_ROOT);
    case (mode)
      0: begin
        return VB'(r * r);
      end
      1: begin
        return VB'(r * r + 1);
      end
      2: begin
        return VB'(r * r - 1);
      end
      3: begin
        return VB'($urandom_range(0, 1023));
      end
      default: begin
        return VB'($urandom);
      end
    endcase
  endfunction

  task automatic send_value(input logic [VB-1:0] v, input logic known,
                            input sqrt_res_t res);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    roots_due.push_back(known ? res : predict_sqrt(v));
  endtask

  task automatic pause_cycles(input int unsigned n);
    start   <= 1'b0;
    value_i <= VB'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (roots_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    sqrt_res_t e;
    if (rst_ni && done_o === 1'b1) begin
      if (roots_due.size() == 0) begin
        $display("%0t: unexpected transaction root=%0d is_square=%0b",
                 $time, root_o, is_square_o);
        n_errors++;
      end else begin
        e = roots_due.pop_front();
        if (root_o !== e.root) begin
          $display("%0t: root expected %0d actual %0d", $time, e.root, root_o);
          n_errors++;
        end
        if (is_square_o !== e.is_sq) begin
          $display("%0t: is_square expected %0b actual %0b", $time, e.is_sq,
                   is_square_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int unsigned i;
    n_errors = 0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    value_i <= '0;
    dir_tbl = '{
      '{31'd0,          1'b1, '{16'd0,     1'b1}},
      '{31'd1,          1'b1, '{16'd1,     1'b1}},
      '{31'd2,          1'b1, '{16'd1,     1'b0}},
      '{31'd3,          1'b1, '{16'd1,     1'b0}},
      '{31'd4,          1'b1, '{16'd2,     1'b1}},
      '{31'h7FFF_FFFF,  1'b1, '{16'd46340, 1'b0}},
      '{31'd2147395600, 1'b1, '{16'd46340, 1'b1}},
      '{31'd2147395599, 1'b1, '{16'd46339, 1'b0}},
      '{31'd2147395601, 1'b1, '{16'd46340, 1'b0}},
      '{31'h4000_0000,  1'b1, '{16'd32768, 1'b1}},
      '{31'h3FFF_FFFF,  1'b1, '{16'd32767, 1'b0}},
      '{31'h5555_5555,  1'b0, '{16'd0,     1'b0}},
      '{31'h2AAA_AAAA,  1'b0, '{16'd0,     1'b0}},
      '{31'd65535,      1'b0, '{16'd0,     1'b0}},
      '{31'd65536,      1'b1, '{16'd256,   1'b1}},
      '{31'd1000000,    1'b0, '{16'd0,     1'b0}}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIR; i++) begin
      send_value(dir_tbl[i].val, dir_tbl[i].known, dir_tbl[i].res);
      if (i % 5 == 4) pause_cycles($urandom_range(1, 18));
    end
    drain();

    for (i = 0; i < N_RAND; i++) begin
      send_value(rand_value(), 1'b0, '0);
      if (i == N_RAND / 2) begin
        drain();
      end else if (i < N_RAND - N_QUIET && (i / 100) % 3 != 2 &&
                   $urandom_range(0, 5) == 0) begin
        pause_cycles($urandom_range(1, 18));
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
